/* rtl/core/afd_pkg.sv */
`timescale 1ns / 1ps

package afd_pkg;

  // fixed field widths
  localparam int unsigned CNT_W = 11;
  localparam int unsigned DSR_W = 11;
  localparam int unsigned PER_W = 32;
  localparam int unsigned DIV_W = 44;
  localparam int unsigned TS_W  = 64;

  // register indexes
  localparam logic [2:0] CFG_HDR_MASK  = 3'd0;
  localparam logic [2:0] CFG_CTL_VALUE = 3'd1;
  localparam logic [2:0] CFG_WATERMARK = 3'd2;
  localparam logic [2:0] CFG_LIMIT     = 3'd3;
  localparam logic [2:0] CFG_INT_TIME  = 3'd4;
  localparam logic [2:0] CFG_PREV_TIME = 3'd5;

  // register reset values
  localparam logic [7:0]       RST_HDR_MASK  = 8'hC0;
  localparam logic [7:0]       RST_CTL_VALUE = 8'h40;
  localparam logic [CNT_W-1:0] RST_WATERMARK = 11'd1022;
  localparam logic [CNT_W-1:0] RST_LIMIT     = 11'd146;

  // axis decode masks
  localparam logic [15:0] AXIS_HI_MASK = 16'hFF00;
  localparam logic [15:0] AXIS_LO_MASK = 16'h000F;

  // result kinds and status codes
  localparam logic       KIND_SAMPLE   = 1'b0;
  localparam logic       KIND_SUMMARY  = 1'b1;
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_DATA  = 2'd1;
  localparam logic [1:0] STAT_TOO_MANY = 2'd2;

  typedef enum logic [1:0] {
    OP_FIRST,
    OP_LAST,
    OP_SPAN
  } op_e;

  typedef struct packed {
    logic [7:0] fifo_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic                    item_kind;
    logic signed [15:0]      accel_x;
    logic signed [15:0]      accel_y;
    logic signed [15:0]      accel_z;
    logic [CNT_W-1:0]        sample_number;
    logic [CNT_W-1:0]        extra_count;
    logic signed [TS_W-1:0]  first_frame_ticks;
    logic signed [TS_W-1:0]  last_frame_ticks;
    logic signed [PER_W-1:0] span_ticks;
    logic [1:0]              status;
    logic                    last_of_run;
  } out_item_t;

  typedef struct packed {
    logic take;
    logic mul;
    logic div_start;
    logic store;
    logic load_sum;
    op_e  op;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic cnt_zero;
    logic over_limit;
    logic div_done;
    logic div_busy;
  } ctl_status_t;

endpackage

/* rtl/core/afd_div.sv */
`timescale 1ns / 1ps

module afd_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [afd_pkg::DIV_W-1:0]   dividend_i,
  input  logic [afd_pkg::DSR_W-1:0]          divisor_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic signed [afd_pkg::DIV_W-1:0]   quotient_o
);
  import afd_pkg::*;

  localparam int unsigned STEP_W = $clog2(DIV_W + 1);

  logic              busy_q, done_q, neg_q;
  logic [STEP_W-1:0] step_q;
  logic [DIV_W-1:0]  quo_q;
  logic [DSR_W:0]    rem_q;
  logic [DSR_W-1:0]  dsr_q;
  logic [DSR_W:0]    rem_sh;
  logic              fits;

  // one restoring step per cycle
  assign rem_sh = {rem_q[DSR_W-1:0], quo_q[DIV_W-1]};
  assign fits   = rem_sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(DIV_W);
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // magnitude datapath, sign applied at the output
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DIV_W-1];
      quo_q <= dividend_i[DIV_W-1] ? DIV_W'(-dividend_i) : DIV_W'(dividend_i);
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

/* rtl/core/afd_datapath.sv */
`timescale 1ns / 1ps

module afd_datapath #(
  parameter int unsigned FIFO_DEPTH_BYTES = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_idx_i,
  input  logic [63:0]           cfg_wdata_i,
  input  afd_pkg::in_item_t     in_item_i,
  input  afd_pkg::ctl_cmd_t     cmd_i,
  output afd_pkg::ctl_status_t  status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output afd_pkg::out_item_t    out_item_o
);
  import afd_pkg::*;

  localparam int unsigned OFS_W = $clog2(FIFO_DEPTH_BYTES + 1);
  localparam int unsigned CMP_W = (OFS_W > CNT_W) ? OFS_W : CNT_W;

  // configuration registers
  logic [7:0]       hdr_mask_q, ctl_value_q;
  logic [CNT_W-1:0] wm_bytes_q, limit_q;
  logic [TS_W-1:0]  int_time_q, prev_time_q;

  // frame state
  logic [OFS_W-1:0] ofs_q, ofs_d;
  logic [2:0]       phase_q, phase_d;
  logic             skip_q, skip_d;
  logic [47:0]      asm_q, asm_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] wm_frame_q, wm_frame_d;
  logic             wm_found_q, wm_found_d;

  // summary arithmetic
  logic signed [DIV_W-1:0] prod_q, fper_q, add_q, span_q;
  logic signed [DIV_W-1:0] quotient;
  logic                    div_busy, div_done;

  logic                  out_valid_q;
  out_item_t             out_q;

  logic                  emit;
  logic [47:0]           frame_word;
  logic [CMP_W:0]        ofs_x, wm_x;
  logic [CNT_W-1:0]      ifr, extra, factor;
  logic signed [PER_W-1:0] period;
  out_item_t             sample, summary;

  function automatic logic [15:0] decode_axis(input logic [15:0] w);
    decode_axis = (w & AXIS_HI_MASK) | ((w & AXIS_LO_MASK) << 4);
  endfunction

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_mask_q  <= RST_HDR_MASK;
      ctl_value_q <= RST_CTL_VALUE;
      wm_bytes_q  <= RST_WATERMARK;
      limit_q     <= RST_LIMIT;
      int_time_q  <= '0;
      prev_time_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HDR_MASK:  hdr_mask_q  <= cfg_wdata_i[7:0];
        CFG_CTL_VALUE: ctl_value_q <= cfg_wdata_i[7:0];
        CFG_WATERMARK: wm_bytes_q  <= cfg_wdata_i[CNT_W-1:0];
        CFG_LIMIT:     limit_q     <= cfg_wdata_i[CNT_W-1:0];
        CFG_INT_TIME:  int_time_q  <= cfg_wdata_i;
        CFG_PREV_TIME: prev_time_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // byte step
  assign ofs_x = (CMP_W+1)'(ofs_q);
  assign wm_x  = (CMP_W+1)'(wm_bytes_q) + (CMP_W+1)'(5);
  assign frame_word = {in_item_i.fifo_byte, asm_q[39:0]};

  always_comb begin
    ofs_d      = ofs_q;
    phase_d    = phase_q;
    skip_d     = skip_q;
    asm_d      = asm_q;
    count_d    = count_q;
    wm_frame_d = wm_frame_q;
    wm_found_d = wm_found_q;
    emit       = 1'b0;
    if (cmd_i.take && (ofs_q < OFS_W'(FIFO_DEPTH_BYTES))) begin
      ofs_d = ofs_q + OFS_W'(1);
      if (skip_q) begin
        skip_d = 1'b0;
      end else if (phase_q == 3'd0) begin
        if ((in_item_i.fifo_byte & hdr_mask_q) == ctl_value_q) begin
          skip_d = 1'b1;
        end else begin
          phase_d = 3'd1;
        end
      end else begin
        asm_d[{phase_q - 3'd1, 3'b000} +: 8] = in_item_i.fifo_byte;
        if (phase_q == 3'd6) begin
          phase_d = 3'd0;
          count_d = count_q + CNT_W'(1);
          emit    = count_q < limit_q;
          if (!wm_found_q && (ofs_x >= wm_x)) begin
            wm_found_d = 1'b1;
            wm_frame_d = count_q;
          end
        end else begin
          phase_d = phase_q + 3'd1;
        end
      end
    end
    if (cmd_i.load_sum) begin
      ofs_d      = '0;
      phase_d    = 3'd0;
      skip_d     = 1'b0;
      count_d    = '0;
      wm_frame_d = '0;
      wm_found_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ofs_q      <= '0;
      phase_q    <= 3'd0;
      skip_q     <= 1'b0;
      count_q    <= '0;
      wm_frame_q <= '0;
      wm_found_q <= 1'b0;
    end else begin
      ofs_q      <= ofs_d;
      phase_q    <= phase_d;
      skip_q     <= skip_d;
      count_q    <= count_d;
      wm_frame_q <= wm_frame_d;
      wm_found_q <= wm_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    asm_q <= asm_d;
  end

  // interrupt frame, trailing count and period
  assign ifr    = wm_found_q ? ((wm_frame_q == '0) ? CNT_W'(1) : wm_frame_q) : count_q;
  assign extra  = (count_q >= ifr) ? (count_q - ifr) : '0;
  assign period = $signed(int_time_q[PER_W-1:0] - prev_time_q[PER_W-1:0]);

  always_comb begin
    case (cmd_i.op)
      OP_FIRST: factor = CNT_W'(1);
      OP_LAST:  factor = extra;
      OP_SPAN:  factor = count_q - CNT_W'(1);
      default:  factor = CNT_W'(1);
    endcase
  end

  // product register ahead of the divider, and quotient registers behind it
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= DIV_W'($signed({1'b0, factor}) * period);
    end
    if (cmd_i.store) begin
      case (cmd_i.op)
        OP_FIRST: fper_q <= quotient;
        OP_LAST:  add_q  <= quotient;
        OP_SPAN:  span_q <= quotient;
        default:  fper_q <= quotient;
      endcase
    end
  end

  afd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (ifr),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // result items
  always_comb begin
    sample               = '0;
    sample.item_kind     = KIND_SAMPLE;
    sample.accel_x       = decode_axis(frame_word[15:0]);
    sample.accel_y       = decode_axis(frame_word[31:16]);
    sample.accel_z       = decode_axis(frame_word[47:32]);
    sample.sample_number = count_q;
    sample.status        = STAT_OK;
    sample.last_of_run   = !in_item_i.final_byte;
  end

  always_comb begin
    summary             = '0;
    summary.item_kind   = KIND_SUMMARY;
    summary.last_of_run = 1'b1;
    if (count_q == '0) begin
      summary.status = STAT_NO_DATA;
    end else begin
      summary.sample_number = count_q;
      summary.extra_count   = extra;
      if (count_q > limit_q) begin
        summary.status = STAT_TOO_MANY;
      end else begin
        summary.status            = STAT_OK;
        summary.first_frame_ticks = $signed(prev_time_q + TS_W'(fper_q));
        summary.last_frame_ticks  = $signed(int_time_q + TS_W'(add_q));
        if (span_q[DIV_W-1:PER_W-1] == '0 || span_q[DIV_W-1:PER_W-1] == '1) begin
          summary.span_ticks = span_q[PER_W-1:0];
        end else begin
          summary.span_ticks = span_q[DIV_W-1] ? {1'b1, {(PER_W-1){1'b0}}}
                                               : {1'b0, {(PER_W-1){1'b1}}};
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.take && emit) || cmd_i.load_sum) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && emit) begin
      out_q <= sample;
    end else if (cmd_i.load_sum) begin
      out_q <= summary;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_item_o          = out_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign status_o.cnt_zero   = count_q == '0;
  assign status_o.over_limit = count_q > limit_q;
  assign status_o.div_done   = div_done;
  assign status_o.div_busy   = div_busy;

endmodule

/* rtl/core/afd_ctrl.sv */
`timescale 1ns / 1ps

module afd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  final_byte_i,
  output logic                  in_ready_o,
  input  afd_pkg::ctl_status_t  status_i,
  output afd_pkg::ctl_cmd_t     cmd_o
);
  import afd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_WAIT,
    ST_LOAD
  } state_e;

  state_e state_q;
  op_e    op_q;
  logic   take;

  assign in_ready_o = (state_q == ST_IDLE) && status_i.out_free;
  assign take       = in_valid_i && in_ready_o;

  // commands per state
  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = op_q;
    cmd_o.take      = take;
    cmd_o.mul       = state_q == ST_MUL;
    cmd_o.div_start = state_q == ST_DIV;
    cmd_o.store     = (state_q == ST_WAIT) && status_i.div_done;
    cmd_o.load_sum  = (state_q == ST_LOAD) && status_i.out_free;
  end

  // sequencer: byte steps, then three multiply-divide passes for a summary (none for an empty or over-limit read)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_FIRST;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (take && final_byte_i) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          op_q <= OP_FIRST;
          if (status_i.cnt_zero || status_i.over_limit) begin
            state_q <= ST_LOAD;
          end else begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: state_q <= ST_DIV;
        ST_DIV: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (status_i.div_done) begin
            case (op_q)
              OP_FIRST: begin
                op_q    <= OP_LAST;
                state_q <= ST_MUL;
              end
              OP_LAST: begin
                op_q    <= OP_SPAN;
                state_q <= ST_MUL;
              end
              default: state_q <= ST_LOAD;
            endcase
          end
        end
        ST_LOAD: begin
          if (status_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_final_starts_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && final_byte_i |=> state_q == ST_CHECK)
    else $error("final item did not start a summary");
  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_sum |-> status_i.out_free)
    else $error("summary loaded over a waiting item");
  a_ready_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !status_i.div_busy)
    else $error("input ready while divider busy");
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> state_q == ST_WAIT)
    else $error("divider finished outside wait state");
`endif

endmodule

/* rtl/core/accel_fifo_frame_deframer.sv */
`timescale 1ns / 1ps
// channel   signals                               direction
// input     in_valid_i / in_ready_o / in_item_i   in  (fifo_byte, final_byte)
// output    out_valid_o / out_ready_i / out_item_o out (sample or summary)
// config    cfg_we_i / cfg_idx_i / cfg_wdata_i    in  (write only, no wait)
//
// a completed data frame under the sample limit loads its sample into the
// output register in the same cycle as its last byte is taken.
// the closing byte holds input ready low through a check state, three passes
// of a multiply state, a divider start state, 44 one-bit divider steps and a
// done wait state, then the load state (no passes for an empty or over-limit read).
// input ready drops while the output register holds an item that is stalled.
// reset (rst_ni low, asynchronous) restores register defaults and frame state.

module accel_fifo_frame_deframer #(
  parameter int unsigned FIFO_DEPTH_BYTES = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  afd_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output afd_pkg::out_item_t out_item_o
);
  import afd_pkg::*;

  ctl_cmd_t    cmd;
  ctl_status_t status;

  afd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .final_byte_i (in_item_i.final_byte),
    .in_ready_o   (in_ready_o),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  afd_datapath #(
    .FIFO_DEPTH_BYTES (FIFO_DEPTH_BYTES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* test/accel_fifo_frame_deframer_tb.sv */
`timescale 1ns / 1ps

module accel_fifo_frame_deframer_tb;
  import afd_pkg::*;

  localparam int unsigned DEPTH     = 1024;
  localparam int unsigned N_RANDOM  = 650;
  localparam longint      MAX_CYCLE = 3000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = CFG_HDR_MASK;
  logic [63:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;

  accel_fifo_frame_deframer #(.FIFO_DEPTH_BYTES(DEPTH)) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow registers
  logic [7:0]       sh_mask;
  logic [7:0]       sh_ctl;
  logic [CNT_W-1:0] sh_wmark;
  logic [CNT_W-1:0] sh_limit;
  logic [63:0]      sh_itime;
  logic [63:0]      sh_ptime;

  // predictor state
  int unsigned  rd_offset, rd_phase, rd_count, rd_wm_frame;
  bit           rd_skip, rd_wm_found;
  logic [47:0]  rd_frame;

  out_item_t    expected_q[$];
  in_item_t     pending_q[$];
  int           errors = 0;
  longint       cycle = 0;
  bit           stim_done = 1'b0;

  function automatic logic [15:0] axis_word(logic [15:0] w);
    return (w & AXIS_HI_MASK) | ((w & AXIS_LO_MASK) << 4);
  endfunction

  task automatic clear_read();
    rd_offset = 0; rd_phase = 0; rd_skip = 0; rd_count = 0;
    rd_wm_frame = 0; rd_wm_found = 0; rd_frame = '0;
  endtask

  // work out the results of one accepted byte
  task automatic predict_byte(in_item_t it);
    out_item_t o;
    int unsigned idx, ifr, extra;
    longint period, fper, add_last, span;
    logic [63:0] diff;
    if (rd_offset < DEPTH) begin
      rd_offset++;
      if (rd_skip) begin
        rd_skip = 0;
      end else if (rd_phase == 0) begin
        if ((it.fifo_byte & sh_mask) == sh_ctl) rd_skip = 1;
        else begin
          rd_phase = 1;
          rd_frame = '0;
        end
      end else begin
        rd_frame[8*(rd_phase-1) +: 8] = it.fifo_byte;
        rd_phase++;
        if (rd_phase > 6) begin
          idx = rd_count;
          rd_phase = 0;
          if (!rd_wm_found && rd_offset - 6 >= sh_wmark) begin
            rd_wm_found = 1;
            rd_wm_frame = idx;
          end
          if (idx < sh_limit) begin
            o = '0;
            o.item_kind = KIND_SAMPLE;
            o.accel_x = axis_word(rd_frame[15:0]);
            o.accel_y = axis_word(rd_frame[31:16]);
            o.accel_z = axis_word(rd_frame[47:32]);
            o.sample_number = idx[CNT_W-1:0];
            o.last_of_run = !it.final_byte;
            expected_q.push_back(o);
          end
          rd_count = (idx + 1) & 11'h7FF;
        end
      end
    end
    if (it.final_byte) begin
      o = '0;
      o.item_kind = KIND_SUMMARY;
      o.last_of_run = 1'b1;
      if (rd_count == 0) begin
        o.status = STAT_NO_DATA;
      end else begin
        ifr = rd_wm_found ? (rd_wm_frame != 0 ? rd_wm_frame : 1) : rd_count;
        extra = rd_count >= ifr ? rd_count - ifr : 0;
        o.sample_number = rd_count[CNT_W-1:0];
        o.extra_count = extra[CNT_W-1:0];
        if (rd_count > sh_limit) begin
          o.status = STAT_TOO_MANY;
        end else begin
          diff = sh_itime - sh_ptime;
          period = longint'(signed'(diff[31:0]));
          fper = period / longint'(ifr);
          add_last = (longint'(extra) * period) / longint'(ifr);
          span = (longint'(rd_count - 1) * period) / longint'(ifr);
          if (span > 64'sd2147483647) span = 64'sd2147483647;
          if (span < -64'sd2147483648) span = -64'sd2147483648;
          o.first_frame_ticks = sh_ptime + fper;
          o.last_frame_ticks = sh_itime + add_last;
          o.span_ticks = span[31:0];
          o.status = STAT_OK;
        end
      end
      expected_q.push_back(o);
      clear_read();
    end
  endtask

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // driver
  int unsigned in_gap = 0;
  bit          hold_in = 1'b0;
  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_byte(in_item_i);
        void'(pending_q.pop_front());
        in_gap = gap_len();
      end
      if (in_valid_i && !in_ready_o) begin
        // hold current item
      end else if (!hold_in && in_gap == 0 && pending_q.size() > 0
                   && !(in_valid_i && in_ready_o && pending_q.size() == 0)) begin
        in_valid_i <= 1'b1;
        in_item_i <= pending_q[0];
      end else begin
        in_valid_i <= 1'b0;
        if (in_gap > 0) in_gap--;
      end
    end
  end

  // monitor
  int unsigned out_gap = 0;
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: %p", out_item_o);
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (out_item_o.item_kind !== e.item_kind) begin
            $error("item_kind exp %0d got %0d", e.item_kind, out_item_o.item_kind); errors++;
          end
          if (out_item_o.accel_x !== e.accel_x) begin
            $error("accel_x exp %0d got %0d", e.accel_x, out_item_o.accel_x); errors++;
          end
          if (out_item_o.accel_y !== e.accel_y) begin
            $error("accel_y exp %0d got %0d", e.accel_y, out_item_o.accel_y); errors++;
          end
          if (out_item_o.accel_z !== e.accel_z) begin
            $error("accel_z exp %0d got %0d", e.accel_z, out_item_o.accel_z); errors++;
          end
          if (out_item_o.sample_number !== e.sample_number) begin
            $error("sample_number exp %0d got %0d", e.sample_number,
                   out_item_o.sample_number); errors++;
          end
          if (out_item_o.extra_count !== e.extra_count) begin
            $error("extra_count exp %0d got %0d", e.extra_count,
                   out_item_o.extra_count); errors++;
          end
          if (out_item_o.first_frame_ticks !== e.first_frame_ticks) begin
            $error("first_frame_ticks exp %0d got %0d", e.first_frame_ticks,
                   out_item_o.first_frame_ticks); errors++;
          end
          if (out_item_o.last_frame_ticks !== e.last_frame_ticks) begin
            $error("last_frame_ticks exp %0d got %0d", e.last_frame_ticks,
                   out_item_o.last_frame_ticks); errors++;
          end
          if (out_item_o.span_ticks !== e.span_ticks) begin
            $error("span_ticks exp %0d got %0d", e.span_ticks, out_item_o.span_ticks);
            errors++;
          end
          if (out_item_o.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_item_o.status); errors++;
          end
          if (out_item_o.last_of_run !== e.last_of_run) begin
            $error("last_of_run exp %0d got %0d", e.last_of_run,
                   out_item_o.last_of_run); errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_ready_i <= 1'b0;
        out_gap--;
      end else begin
        out_ready_i <= 1'b1;
        out_gap = gap_len();
      end
    end
  end

  // timeout
  always @(posedge clk_i) begin
    if (cycle > MAX_CYCLE) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_HDR_MASK:  sh_mask = val[7:0];
      CFG_CTL_VALUE: sh_ctl = val[7:0];
      CFG_WATERMARK: sh_wmark = val[CNT_W-1:0];
      CFG_LIMIT:     sh_limit = val[CNT_W-1:0];
      CFG_INT_TIME:  sh_itime = val;
      CFG_PREV_TIME: sh_ptime = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait for the block to drain, including a summary still in flight
  task automatic drain();
    while (pending_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic push(logic [7:0] b, bit fin);
    in_item_t it;
    it.fifo_byte = b;
    it.final_byte = fin;
    pending_q.push_back(it);
  endtask

  // one data frame with random content
  task automatic push_frame(logic [7:0] hdr, bit fin_last);
    push(hdr, 1'b0);
    for (int i = 0; i < 6; i++) push($urandom_range(0, 255), fin_last && i == 5);
  endtask

  // header that is a data frame under the current mode setting
  function automatic logic [7:0] data_hdr();
    logic [7:0] h;
    h = $urandom_range(0, 255);
    if ((h & sh_mask) == sh_ctl) h = h ^ (sh_mask == 0 ? 8'h00 : sh_mask & -sh_mask);
    return h;
  endfunction

  function automatic logic [7:0] ctl_hdr();
    logic [7:0] h;
    h = $urandom_range(0, 255);
    return (h & ~sh_mask) | (sh_ctl & sh_mask);
  endfunction

  // a random read of n frames, mixed with control frames and noise
  task automatic push_read(int unsigned frames, bit partial);
    for (int unsigned f = 0; f < frames; f++) begin
      if ($urandom_range(0, 5) == 0) begin
        push(ctl_hdr(), 1'b0);
        push($urandom_range(0, 255), 1'b0);
      end
      push_frame(data_hdr(), 1'b0);
    end
    if (partial) for (int i = $urandom_range(1, 6); i > 0; i--) push($urandom_range(0, 255), 1'b0);
    push(ctl_hdr(), 1'b0);
    push($urandom_range(0, 255), 1'b1);
  endtask

  int unsigned sent;

  initial begin
    sh_mask = RST_HDR_MASK; sh_ctl = RST_CTL_VALUE;
    sh_wmark = RST_WATERMARK; sh_limit = RST_LIMIT;
    sh_itime = '0; sh_ptime = '0;
    clear_read();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: reset settings, empty read, extremes of axis bytes
    push(8'h00, 1'b1);
    push_frame(8'h00, 1'b0);
    for (int i = 0; i < 6; i++) pending_q[pending_q.size()-6+i].fifo_byte = 8'hFF;
    push_frame(8'hFF, 1'b1);
    drain();

    write_reg(CFG_INT_TIME, 64'd5000);
    write_reg(CFG_PREV_TIME, 64'd1000);
    write_reg(CFG_WATERMARK, 11'd0);
    write_reg(CFG_LIMIT, 11'd1);
    // control frame, sample limit hit, final byte with header only
    push(8'h40, 1'b0); push(8'h12, 1'b0);
    push_frame(8'h80, 1'b0);
    push_frame(8'h01, 1'b0);
    push(8'h00, 1'b1);
    drain();
    write_reg(CFG_LIMIT, 11'd1024);
    push_frame(8'h00, 1'b0);
    push_frame(8'h00, 1'b1);
    drain();

    // time registers at the 64-bit extremes; their low 32 bits give a period of -1
    write_reg(CFG_INT_TIME, 64'h7FFF_FFFF_FFFF_FFFF);
    write_reg(CFG_PREV_TIME, 64'h8000_0000_0000_0000);
    write_reg(CFG_WATERMARK, 11'd1024);
    push_read(3, 1'b1);
    drain();

    // past fifo depth: bytes ignored, final still summarizes
    write_reg(CFG_HDR_MASK, 8'h00);
    write_reg(CFG_CTL_VALUE, 8'hFF);
    for (int i = 0; i < DEPTH + 10; i++) push($urandom_range(0, 255), i == DEPTH + 9);
    drain();

    // random phases with changing settings
    sent = 0;
    while (sent < N_RANDOM) begin
      write_reg(CFG_HDR_MASK, $urandom_range(0, 3) == 0 ? 8'hFF : $urandom_range(0, 255));
      write_reg(CFG_CTL_VALUE, $urandom_range(0, 1) ? (sh_mask & $urandom_range(0, 255))
                                                    : $urandom_range(0, 255));
      write_reg(CFG_WATERMARK, $urandom_range(0, 3) == 0 ? 11'd1024 : $urandom_range(0, 200));
      write_reg(CFG_LIMIT, $urandom_range(0, 4) == 0 ? 11'd0 : $urandom_range(1, 40));
      write_reg(CFG_INT_TIME, rand64());
      write_reg(CFG_PREV_TIME, $urandom_range(0, 1) ? sh_itime - $urandom_range(0, 100000)
                                                     : rand64());
      for (int r = 0; r < 4; r++) begin
        int unsigned before_n;
        before_n = pending_q.size();
        if ($urandom_range(0, 7) == 0) begin
          for (int k = $urandom_range(1, 20); k > 0; k--)
            push($urandom_range(0, 255), k == 1);
        end else begin
          push_read($urandom_range(0, 25), $urandom_range(0, 3) == 0);
        end
        sent += pending_q.size() - before_n;
        if ($urandom_range(0, 5) == 0) begin
          // sender holds off until all results are in
          hold_in = 1'b1;
          while (pending_q.size() > 0 || in_valid_i) begin
            hold_in = 1'b0;
            @(posedge clk_i);
          end
          while (expected_q.size() > 0) @(posedge clk_i);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* accel_fifo_frame_deframer.f */
rtl/core/afd_pkg.sv
rtl/core/afd_div.sv
rtl/core/afd_datapath.sv
rtl/core/afd_ctrl.sv
rtl/core/accel_fifo_frame_deframer.sv
test/accel_fifo_frame_deframer_tb.sv
